[src/woc_pkg.sv]
// Shared constants and helpers for the weld orientation cost pipeline.
package woc_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int ISQRT_STEPS = 32;   // 63-bit radicand, two bits per step
  localparam int SQ_W = 64;          // radicand and root working width
  localparam int CORDIC_W = 35;      // signed CORDIC x/y width
  localparam int ANGLE_W = 19;       // signed Q16 angle accumulator
  localparam int QANG_W = 17;        // clamped Q16 angle, 0..pi/2
  localparam int HALF_PI_Q16 = 102944;
  localparam int PI_Q16 = 205887;
  localparam int COST_MAX = 262143;
  localparam int WEIGHT_W = 16;
  localparam int WEIGHT_X_RESET = 256;
  localparam int WEIGHT_Y_RESET = 2560;

  typedef enum logic {
    REG_WEIGHT_X = 1'b0,
    REG_WEIGHT_Y = 1'b1
  } cfg_reg_t;

  // atan(2^-i) in Q16 for CORDIC step i
  function automatic logic signed [ANGLE_W-1:0] atan_step(input int i);
    logic signed [ANGLE_W-1:0] r;
    case (i)
      0: r = ANGLE_W'(51472);
      1: r = ANGLE_W'(30386);
      2: r = ANGLE_W'(16055);
      3: r = ANGLE_W'(8150);
      4: r = ANGLE_W'(4091);
      5: r = ANGLE_W'(2047);
      default: r = (i <= 16) ? ANGLE_W'(1 << (16 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

[src/woc_isqrt.sv]
// Pipelined floor integer square root, one result bit per stage, with sideband.
module woc_isqrt #(
  parameter int PW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [woc_pkg::SQ_W-1:0]    radicand,
  input  logic [PW-1:0]               in_pay,
  output logic                        out_valid,
  output logic [woc_pkg::SQ_W/2-1:0]  root,
  output logic [PW-1:0]               out_pay
);
  localparam int STEPS = woc_pkg::ISQRT_STEPS;
  localparam int W = woc_pkg::SQ_W;

  logic [W-1:0]  n_q   [STEPS+1];
  logic [W-1:0]  res_q [STEPS+1];
  logic [PW-1:0] pay_q [STEPS+1];
  logic          vld_q [STEPS+1];

  assign n_q[0]   = radicand;
  assign res_q[0] = '0;
  assign pay_q[0] = in_pay;
  assign vld_q[0] = in_valid;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] trial;
    logic         take;
    assign trial = res_q[k] + BIT;
    assign take  = n_q[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
      if (en) begin
        n_q[k+1]   <= take ? n_q[k] - trial : n_q[k];
        res_q[k+1] <= take ? (res_q[k] >> 1) + BIT : res_q[k] >> 1;
        pay_q[k+1] <= pay_q[k];
      end
    end
  end

  assign out_valid = vld_q[STEPS];
  assign root      = res_q[STEPS][W/2-1:0];
  assign out_pay   = pay_q[STEPS];
endmodule

[src/woc_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) for x, y >= 0 as a clamped Q16 angle.
module woc_cordic #(
  parameter int ITER = woc_pkg::ANGLE_ITERATIONS_DEF,
  parameter int PW   = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [woc_pkg::CORDIC_W-1:0]     x_in,
  input  logic [woc_pkg::CORDIC_W-1:0]     y_in,
  input  logic [PW-1:0]                    in_pay,
  output logic                             out_valid,
  output logic [woc_pkg::QANG_W-1:0]       angle,
  output logic [PW-1:0]                    out_pay
);
  localparam int CW = woc_pkg::CORDIC_W;
  localparam int ZW = woc_pkg::ANGLE_W;

  logic signed [CW-1:0] x_q   [ITER+1];
  logic signed [CW-1:0] y_q   [ITER+1];
  logic signed [ZW-1:0] z_q   [ITER+1];
  logic                 yz_q  [ITER+1];
  logic [PW-1:0]        pay_q [ITER+1];
  logic                 vld_q [ITER+1];

  assign x_q[0]   = x_in;
  assign y_q[0]   = y_in;
  assign z_q[0]   = '0;
  assign yz_q[0]  = (y_in == '0);   // zero y: angle is exactly 0
  assign pay_q[0] = in_pay;
  assign vld_q[0] = in_valid;

  for (genvar i = 0; i < ITER; i++) begin : g_step
    localparam logic signed [ZW-1:0] STEP = woc_pkg::atan_step(i);
    logic pos;
    assign pos = (y_q[i] > 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
      if (en) begin
        x_q[i+1]   <= pos ? x_q[i] + (y_q[i] >>> i) : x_q[i] - (y_q[i] >>> i);
        y_q[i+1]   <= pos ? y_q[i] - (x_q[i] >>> i) : y_q[i] + (x_q[i] >>> i);
        z_q[i+1]   <= pos ? z_q[i] + STEP : z_q[i] - STEP;
        yz_q[i+1]  <= yz_q[i];
        pay_q[i+1] <= pay_q[i];
      end
    end
  end

  always_comb begin
    if (yz_q[ITER] || z_q[ITER] < 0) begin
      angle = '0;
    end else if (z_q[ITER] > ZW'(woc_pkg::HALF_PI_Q16)) begin
      angle = woc_pkg::QANG_W'(woc_pkg::HALF_PI_Q16);
    end else begin
      angle = z_q[ITER][woc_pkg::QANG_W-1:0];
    end
  end

  assign out_valid = vld_q[ITER];
  assign out_pay   = pay_q[ITER];
endmodule

[src/weld_orientation_cost.sv]
// Weld orientation cost: relative Z axis tilt angles and their weighted sum.
//
// Fully pipelined: one pose beat is accepted every clock while the output
// side takes results, and each result passes through 5 front stages for
// the matrix product and squares, 32 square-root stages, ANGLE_ITERATIONS
// CORDIC stages and 3 stages for rounding and weighting. The whole pipe
// advances together; it halts only while a finished result is held at the
// output and not taken. Weights come from the write port and should change
// only while no beat is in flight.
module weld_orientation_cost #(
  parameter int ANGLE_ITERATIONS = woc_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ref_m00, ref_m01, ref_m02, ref_m10, ref_m11, ref_m12, ref_m20, ref_m21,
  // ref_m22, cand_z_x, cand_z_y, cand_z_z (16 bits each, lowest first)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // weld_cost[17:0], angle_about_x[30:18], angle_about_y[44:31], zero pad
  output logic [47:0]  m_tdata,
  // degenerate
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam int CW = woc_pkg::CORDIC_W;
  localparam int QW = woc_pkg::QANG_W;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // configuration
  logic [woc_pkg::WEIGHT_W-1:0] weight_x, weight_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_x <= woc_pkg::WEIGHT_W'(woc_pkg::WEIGHT_X_RESET);
      weight_y <= woc_pkg::WEIGHT_W'(woc_pkg::WEIGHT_Y_RESET);
    end else if (cfg_we) begin
      case (woc_pkg::cfg_reg_t'(cfg_index))
        woc_pkg::REG_WEIGHT_X: weight_x <= cfg_data;
        woc_pkg::REG_WEIGHT_Y: weight_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: the nine products R[k][i] * c[k]
  logic signed [31:0] prod [9];
  logic               v1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod[i*3+k] <= $signed(s_tdata[(k*3+i)*16 +: 16]) *
                         $signed(s_tdata[(9+k)*16 +: 16]);
        end
      end
    end
  end

  // stage 2: v = R^T c
  logic signed [33:0] vec [3];
  logic               v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vec[i] <= 34'(prod[i*3]) + 34'(prod[i*3+1]) + 34'(prod[i*3+2]);
      end
    end
  end

  // stage 3: halved magnitudes and flags
  logic [33:0] mag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][33] ? 34'(-vec[i]) : 34'(vec[i]);
    end
  end

  logic [30:0] ax3, ay3, az3;
  logic        deg3, neg3, v3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      ax3  <= mag[0][31:1];
      ay3  <= mag[1][31:1];
      az3  <= mag[2][31:1];
      deg3 <= (vec[0] == '0) && (vec[2] == '0);
      neg3 <= vec[2][33];
    end
  end

  // stage 4: squares
  logic [61:0] sqx4, sqz4;
  logic [30:0] ax4, ay4, az4;
  logic        deg4, neg4, v4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      sqx4 <= 62'(ax3) * 62'(ax3);
      sqz4 <= 62'(az3) * 62'(az3);
      ax4  <= ax3;
      ay4  <= ay3;
      az4  <= az3;
      deg4 <= deg3;
      neg4 <= neg3;
    end
  end

  // stage 5: radicand
  logic [woc_pkg::SQ_W-1:0] rad5;
  logic [94:0]              pay5;
  logic                     v5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      rad5 <= woc_pkg::SQ_W'(sqx4) + woc_pkg::SQ_W'(sqz4);
      pay5 <= {deg4, neg4, ax4, ay4, az4};
    end
  end

  logic                       sq_valid;
  logic [woc_pkg::SQ_W/2-1:0] mxz;
  logic [94:0]                sq_pay;

  woc_isqrt #(.PW(95)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .radicand  (rad5),
    .in_pay    (pay5),
    .out_valid (sq_valid),
    .root      (mxz),
    .out_pay   (sq_pay)
  );

  logic        cx_valid, cy_valid, deg_c, neg_c;
  logic [QW-1:0] ang_x, ang_y_raw;

  woc_cordic #(.ITER(ANGLE_ITERATIONS), .PW(1)) u_cordic_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .x_in      (CW'(mxz)),
    .y_in      (CW'(sq_pay[61:31])),
    .in_pay    (sq_pay[94]),
    .out_valid (cx_valid),
    .angle     (ang_x),
    .out_pay   (deg_c)
  );

  woc_cordic #(.ITER(ANGLE_ITERATIONS), .PW(1)) u_cordic_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .x_in      (CW'(sq_pay[30:0])),
    .y_in      (CW'(sq_pay[92:62])),
    .in_pay    (sq_pay[93]),
    .out_valid (cy_valid),
    .angle     (ang_y_raw),
    .out_pay   (neg_c)
  );

  // rounding to Q12; a negative v.z folds the Y tilt past pi/2
  logic [17:0] ang_y_full;
  logic [17:0] qx_sum, qy_sum;
  assign ang_y_full = neg_c ? 18'(woc_pkg::PI_Q16) - 18'(ang_y_raw) : 18'(ang_y_raw);
  assign qx_sum     = 18'(ang_x) + 18'd8;
  assign qy_sum     = ang_y_full + 18'd8;

  logic [12:0] qx6;
  logic [13:0] qy6;
  logic        deg6, v6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= cx_valid && cy_valid;
    end
    if (en) begin
      qx6  <= deg_c ? '0 : qx_sum[16:4];
      qy6  <= deg_c ? '0 : qy_sum[17:4];
      deg6 <= deg_c;
    end
  end

  // weighting
  logic [28:0] px7;
  logic [29:0] py7;
  logic [12:0] qx7;
  logic [13:0] qy7;
  logic        deg7, v7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      px7  <= 29'(weight_x) * 29'(qx6);
      py7  <= 30'(weight_y) * 30'(qy6);
      qx7  <= qx6;
      qy7  <= qy6;
      deg7 <= deg6;
    end
  end

  logic [30:0] sum7;
  logic [22:0] cost7;
  assign sum7  = 31'(px7) + 31'(py7) + 31'd128;
  assign cost7 = sum7[30:8];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v7;
    end
    if (en) begin
      m_tdata[17:0]  <= (cost7 > 23'(woc_pkg::COST_MAX)) ? 18'(woc_pkg::COST_MAX)
                                                         : cost7[17:0];
      m_tdata[30:18] <= qx7;
      m_tdata[44:31] <= qy7;
      m_tdata[47:45] <= '0;
      m_tuser        <= deg7;
    end
  end

`ifndef SYNTH
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[44:0] == '0)
    else $error("degenerate result carries nonzero cost or angles");

  a_angle_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[30:18] <= 13'd6434)
    else $error("angle_about_x above pi/2");

  a_angle_y_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[44:31] <= 14'd12868)
    else $error("angle_about_y above pi");

  a_cordic_lockstep: assert property (@(posedge clk) disable iff (rst)
    cx_valid == cy_valid)
    else $error("CORDIC lanes out of step");
`endif
endmodule
